// File: src/ksts_pkg.sv
// ----------------------------------------------------------------------------
// ksts_pkg
// Shared opcodes, configuration register indexes and fixed field widths of
// the keyed slot table.
// ----------------------------------------------------------------------------
package ksts_pkg;

    // Fixed widths of the request opcode and the configuration index.
    localparam int OPCODE_BITS  = 4;
    localparam int CFG_IDX_BITS = 2;

    // Request opcodes.
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ADD    = 4'd0,
        OP_REMOVE = 4'd1,
        OP_MOVE   = 4'd2,
        OP_FIND   = 4'd3,
        OP_BASE   = 4'd4,
        OP_EMPTY  = 4'd5,
        OP_COUNT  = 4'd6,
        OP_READ   = 4'd7,
        OP_LEADER = 4'd8
    } op_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDE_MODE      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEADER_KEY     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LEADER_PRESENT = 2'd2;

endpackage

// File: src/ksts_in_if.sv
// ----------------------------------------------------------------------------
// ksts_in_if
// Request channel of the keyed slot table: valid/ready plus the request fields.
// ----------------------------------------------------------------------------
interface ksts_in_if
    import ksts_pkg::*;
#(
    parameter int KEY_BITS  = 16,
    parameter int SLOT_BITS = 5
);

    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [KEY_BITS-1:0]    member_key;
    logic [SLOT_BITS-1:0]   slot_index;

    modport source (
        output valid,
        output opcode,
        output member_key,
        output slot_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  member_key,
        input  slot_index,
        output ready
    );

endinterface

// File: src/ksts_out_if.sv
// ----------------------------------------------------------------------------
// ksts_out_if
// Result channel of the keyed slot table: valid/ready plus the result fields.
// ----------------------------------------------------------------------------
interface ksts_out_if #(
    parameter int KEY_BITS     = 16,
    parameter int SLOT_BITS    = 5,
    parameter int SUB_CNT_BITS = 4,
    parameter int MEM_CNT_BITS = 6
);

    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic [SLOT_BITS-1:0]    slot_out;
    logic [KEY_BITS-1:0]     key_out;
    logic                    key_valid;
    logic [SUB_CNT_BITS-1:0] subgroup_count;
    logic [MEM_CNT_BITS-1:0] member_count;

    modport source (
        output valid,
        output ok,
        output slot_out,
        output key_out,
        output key_valid,
        output subgroup_count,
        output member_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  ok,
        input  slot_out,
        input  key_out,
        input  key_valid,
        input  subgroup_count,
        input  member_count,
        output ready
    );

endinterface

// File: src/ksts_ram.sv
// ----------------------------------------------------------------------------
// ksts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ksts_ram #(
    parameter int  WIDTH     = 16,
    parameter int  DEPTH     = 32,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; a read of the address being written returns
    // the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ksts_engine.sv
// ----------------------------------------------------------------------------
// ksts_engine
// Sequencer of the keyed slot table. Keeps the slot valid bits, occupancy and
// configuration registers, scans the key memory one slot per cycle and
// performs the read-modify-write of each operation.
// ----------------------------------------------------------------------------
module ksts_engine
    import ksts_pkg::*;
#(
    parameter int  TABLE_SLOTS    = 32,
    parameter int  SUBGROUP_SLOTS = 8,
    parameter int  KEY_BITS       = 16,
    localparam int SLOT_BITS      = $clog2(TABLE_SLOTS),
    localparam int SUB_CNT_BITS   = $clog2(SUBGROUP_SLOTS + 1),
    localparam int MEM_CNT_BITS   = $clog2(TABLE_SLOTS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration writes.
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [KEY_BITS-1:0]     cfg_data,
    // Request side.
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic [OPCODE_BITS-1:0]  req_opcode,
    input  logic [KEY_BITS-1:0]     req_key,
    input  logic [SLOT_BITS-1:0]    req_slot,
    // Result side.
    output logic                    res_valid,
    input  logic                    res_take,
    output logic                    res_ok,
    output logic [SLOT_BITS-1:0]    res_slot,
    output logic [KEY_BITS-1:0]     res_key,
    output logic                    res_key_valid,
    output logic [SUB_CNT_BITS-1:0] res_sub_count,
    output logic [MEM_CNT_BITS-1:0] res_mem_count,
    // Key memory.
    output logic                    ram_we,
    output logic [SLOT_BITS-1:0]    ram_waddr,
    output logic [KEY_BITS-1:0]     ram_wdata,
    output logic [SLOT_BITS-1:0]    ram_raddr,
    input  logic [KEY_BITS-1:0]     ram_rdata
);

    localparam int IDX_BITS   = SLOT_BITS + 1;
    localparam int POS_BITS   = $clog2(SUBGROUP_SLOTS);
    localparam int GRP_BITS   = IDX_BITS + SUB_CNT_BITS;
    localparam int NARROW_END = (SUBGROUP_SLOTS < TABLE_SLOTS) ? SUBGROUP_SLOTS : TABLE_SLOTS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_MV_RD,
        S_MV_WR1,
        S_MV_WR2,
        S_DONE
    } state_t;

    state_t                  state_reg,          state_next;
    op_t                     op_reg,             op_next;
    logic [KEY_BITS-1:0]     key_reg,            key_next;
    logic [SLOT_BITS-1:0]    slot_reg,           slot_next;
    logic                    slot_ok_reg,        slot_ok_next;
    logic [IDX_BITS-1:0]     scan_idx_reg,       scan_idx_next;
    logic [IDX_BITS-1:0]     scan_end_reg,       scan_end_next;
    logic [SLOT_BITS-1:0]    scan_base_reg,      scan_base_next;
    logic [POS_BITS-1:0]     scan_pos_reg,       scan_pos_next;
    logic                    cmp_vld_reg,        cmp_vld_next;
    logic [SLOT_BITS-1:0]    cmp_idx_reg,        cmp_idx_next;
    logic [SLOT_BITS-1:0]    cmp_base_reg,       cmp_base_next;
    logic                    cmp_grp_reg,        cmp_grp_next;
    logic [SLOT_BITS-1:0]    hit_reg,            hit_next;
    logic [SUB_CNT_BITS-1:0] cnt_reg,            cnt_next;
    logic [TABLE_SLOTS-1:0]  valid_reg,          valid_next;
    logic [MEM_CNT_BITS-1:0] occ_reg,            occ_next;
    logic                    wide_mode_reg,      wide_mode_next;
    logic [KEY_BITS-1:0]     leader_key_reg,     leader_key_next;
    logic                    leader_present_reg, leader_present_next;
    logic                    res_ok_reg,         res_ok_next;
    logic [SLOT_BITS-1:0]    res_slot_reg,       res_slot_next;
    logic [KEY_BITS-1:0]     res_key_reg,        res_key_next;
    logic                    res_kv_reg,         res_kv_next;
    logic [SUB_CNT_BITS-1:0] res_cnt_reg,        res_cnt_next;

    logic                    req_in_range;
    logic                    cmp_valid_bit;
    logic                    cmp_key_eq;
    logic                    cmp_last;
    logic                    issue_in_grp;
    logic [GRP_BITS-1:0]     grp_lo;
    logic [GRP_BITS-1:0]     slot_wide;

    // Compare-stage terms of the slot scan.
    assign req_in_range  = IDX_BITS'(req_slot) < IDX_BITS'(TABLE_SLOTS);
    assign cmp_valid_bit = valid_reg[cmp_idx_reg];
    assign cmp_key_eq    = ram_rdata == key_reg;
    assign cmp_last      = (IDX_BITS'(cmp_idx_reg) + IDX_BITS'(1)) == scan_end_reg;

    // Whether the slot being issued lies in the subgroup of the addressed slot.
    assign grp_lo       = GRP_BITS'(scan_base_reg);
    assign slot_wide    = GRP_BITS'(slot_reg);
    assign issue_in_grp = (slot_wide >= grp_lo) &&
                          (slot_wide < grp_lo + GRP_BITS'(SUBGROUP_SLOTS));

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next          = state_reg;
        op_next             = op_reg;
        key_next            = key_reg;
        slot_next           = slot_reg;
        slot_ok_next        = slot_ok_reg;
        scan_idx_next       = scan_idx_reg;
        scan_end_next       = scan_end_reg;
        scan_base_next      = scan_base_reg;
        scan_pos_next       = scan_pos_reg;
        cmp_vld_next        = cmp_vld_reg;
        cmp_idx_next        = cmp_idx_reg;
        cmp_base_next       = cmp_base_reg;
        cmp_grp_next        = cmp_grp_reg;
        hit_next            = hit_reg;
        cnt_next            = cnt_reg;
        valid_next          = valid_reg;
        occ_next            = occ_reg;
        wide_mode_next      = wide_mode_reg;
        leader_key_next     = leader_key_reg;
        leader_present_next = leader_present_reg;
        res_ok_next         = res_ok_reg;
        res_slot_next       = res_slot_reg;
        res_key_next        = res_key_reg;
        res_kv_next         = res_kv_reg;
        res_cnt_next        = res_cnt_reg;
        ram_we              = 1'b0;
        ram_waddr           = cmp_idx_reg;
        ram_wdata           = key_reg;
        ram_raddr           = scan_idx_reg[SLOT_BITS-1:0];

        // Configuration writes; the user must issue them only while the block is idle; the block does not enforce it.
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDE_MODE:      wide_mode_next      = cfg_data[0];
                CFG_LEADER_KEY:     leader_key_next     = cfg_data;
                CFG_LEADER_PRESENT: leader_present_next = cfg_data[0];
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                // A read request fetches its slot at the acceptance edge.
                ram_raddr = req_slot;
                if (req_valid)
                begin
                    op_next        = op_t'(req_opcode);
                    key_next       = req_key;
                    slot_next      = req_slot;
                    slot_ok_next   = req_in_range;
                    scan_idx_next  = '0;
                    scan_end_next  = IDX_BITS'(TABLE_SLOTS);
                    scan_base_next = '0;
                    scan_pos_next  = '0;
                    cmp_vld_next   = 1'b0;
                    cnt_next       = '0;
                    res_ok_next    = 1'b0;
                    res_slot_next  = '0;
                    res_key_next   = '0;
                    res_kv_next    = 1'b0;
                    res_cnt_next   = '0;
                    case (op_t'(req_opcode))
                        OP_ADD:
                        begin
                            scan_end_next = wide_mode_reg ? IDX_BITS'(TABLE_SLOTS)
                                                          : IDX_BITS'(NARROW_END);
                            state_next    = S_SCAN;
                        end
                        OP_REMOVE, OP_MOVE, OP_FIND, OP_BASE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_EMPTY:
                        begin
                            // Slot zero and slots past the table never read as empty.
                            res_ok_next = (req_slot != '0) && req_in_range &&
                                          !valid_reg[req_slot];
                            state_next  = S_DONE;
                        end
                        OP_COUNT:
                        begin
                            state_next = req_in_range ? S_SCAN : S_DONE;
                        end
                        OP_READ:
                        begin
                            state_next = req_in_range ? S_READ : S_DONE;
                        end
                        OP_LEADER:
                        begin
                            res_ok_next = leader_present_reg && (req_key == leader_key_reg);
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue stage: one slot address per cycle, tracking the subgroup base.
                if (scan_idx_reg < scan_end_reg)
                begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[SLOT_BITS-1:0];
                    cmp_base_next = scan_base_reg;
                    cmp_grp_next  = issue_in_grp;
                    scan_idx_next = scan_idx_reg + IDX_BITS'(1);
                    if (scan_pos_reg == POS_BITS'(SUBGROUP_SLOTS - 1))
                    begin
                        scan_pos_next  = '0;
                        scan_base_next = SLOT_BITS'(scan_base_reg + SUBGROUP_SLOTS);
                    end
                    else
                    begin
                        scan_pos_next = scan_pos_reg + POS_BITS'(1);
                    end
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end

                // Compare stage: memory data for the slot issued in the previous cycle.
                if (cmp_vld_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (!cmp_valid_bit)
                        begin
                            ram_we                  = 1'b1;
                            ram_waddr               = cmp_idx_reg;
                            ram_wdata               = key_reg;
                            valid_next[cmp_idx_reg] = 1'b1;
                            occ_next                = occ_reg + MEM_CNT_BITS'(1);
                            res_ok_next             = 1'b1;
                            res_slot_next           = cmp_idx_reg;
                            state_next              = S_DONE;
                        end
                        else if (cmp_last)
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else if (op_reg == OP_COUNT)
                    begin
                        cnt_next = cnt_reg + SUB_CNT_BITS'(cmp_valid_bit && cmp_grp_reg);
                        if (cmp_last)
                        begin
                            res_ok_next  = 1'b1;
                            res_cnt_next = cnt_next;
                            state_next   = S_DONE;
                        end
                    end
                    else if (cmp_valid_bit && cmp_key_eq)
                    begin
                        // First slot holding the key.
                        state_next = S_DONE;
                        case (op_reg)
                            OP_REMOVE:
                            begin
                                valid_next[cmp_idx_reg] = 1'b0;
                                occ_next                = occ_reg - MEM_CNT_BITS'(1);
                                res_ok_next             = 1'b1;
                            end
                            OP_FIND:
                            begin
                                res_ok_next   = 1'b1;
                                res_slot_next = cmp_idx_reg;
                            end
                            OP_BASE:
                            begin
                                res_ok_next   = 1'b1;
                                res_slot_next = cmp_base_reg;
                            end
                            OP_MOVE:
                            begin
                                if ((cmp_idx_reg != slot_reg) && slot_ok_reg)
                                begin
                                    hit_next   = cmp_idx_reg;
                                    state_next = S_MV_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                    else if (cmp_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                // Memory data for the slot fetched at acceptance.
                res_ok_next  = valid_reg[slot_reg];
                res_kv_next  = valid_reg[slot_reg];
                res_key_next = valid_reg[slot_reg] ? ram_rdata : '0;
                state_next   = S_DONE;
            end

            S_MV_RD:
            begin
                // Fetch the current occupant of the target slot.
                ram_raddr  = slot_reg;
                state_next = S_MV_WR1;
            end

            S_MV_WR1:
            begin
                // The target's former contents go to the key's old slot.
                ram_we                = 1'b1;
                ram_waddr             = hit_reg;
                ram_wdata             = ram_rdata;
                valid_next[hit_reg]   = valid_reg[slot_reg];
                valid_next[slot_reg]  = 1'b1;
                state_next            = S_MV_WR2;
            end

            S_MV_WR2:
            begin
                ram_we      = 1'b1;
                ram_waddr   = slot_reg;
                ram_wdata   = key_reg;
                res_ok_next = 1'b1;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            op_reg             <= OP_ADD;
            key_reg            <= '0;
            slot_reg           <= '0;
            slot_ok_reg        <= 1'b0;
            scan_idx_reg       <= '0;
            scan_end_reg       <= '0;
            scan_base_reg      <= '0;
            scan_pos_reg       <= '0;
            cmp_vld_reg        <= 1'b0;
            cmp_idx_reg        <= '0;
            cmp_base_reg       <= '0;
            cmp_grp_reg        <= 1'b0;
            hit_reg            <= '0;
            cnt_reg            <= '0;
            valid_reg          <= '0;
            occ_reg            <= '0;
            wide_mode_reg      <= 1'b0;
            leader_key_reg     <= '0;
            leader_present_reg <= 1'b0;
            res_ok_reg         <= 1'b0;
            res_slot_reg       <= '0;
            res_key_reg        <= '0;
            res_kv_reg         <= 1'b0;
            res_cnt_reg        <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            op_reg             <= op_next;
            key_reg            <= key_next;
            slot_reg           <= slot_next;
            slot_ok_reg        <= slot_ok_next;
            scan_idx_reg       <= scan_idx_next;
            scan_end_reg       <= scan_end_next;
            scan_base_reg      <= scan_base_next;
            scan_pos_reg       <= scan_pos_next;
            cmp_vld_reg        <= cmp_vld_next;
            cmp_idx_reg        <= cmp_idx_next;
            cmp_base_reg       <= cmp_base_next;
            cmp_grp_reg        <= cmp_grp_next;
            hit_reg            <= hit_next;
            cnt_reg            <= cnt_next;
            valid_reg          <= valid_next;
            occ_reg            <= occ_next;
            wide_mode_reg      <= wide_mode_next;
            leader_key_reg     <= leader_key_next;
            leader_present_reg <= leader_present_next;
            res_ok_reg         <= res_ok_next;
            res_slot_reg       <= res_slot_next;
            res_key_reg        <= res_key_next;
            res_kv_reg         <= res_kv_next;
            res_cnt_reg        <= res_cnt_next;
        end
    end

    // Handshake and result outputs.
    assign req_ready     = state_reg == S_IDLE;
    assign res_valid     = state_reg == S_DONE;
    assign res_ok        = res_ok_reg;
    assign res_slot      = res_slot_reg;
    assign res_key       = res_key_reg;
    assign res_key_valid = res_kv_reg;
    assign res_sub_count = res_cnt_reg;
    assign res_mem_count = occ_reg;

    // The occupancy count always matches the number of valid slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == occ_reg)
        else $error("occupancy count differs from valid slot count");

    // An accepted request always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start");

    // The key memory is written only by an add hit or the move sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_SCAN || state_reg == S_MV_WR1 ||
                    state_reg == S_MV_WR2))
        else $error("key memory written outside an update step");

    // A move never swaps a slot with itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MV_WR1) |-> (hit_reg != slot_reg))
        else $error("move target equals source slot");

    // The compare stage only looks at slots inside the scan window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_vld_reg) |-> (IDX_BITS'(cmp_idx_reg) < scan_end_reg))
        else $error("scan compared a slot past its window");

endmodule

// File: src/keyed_slot_table_with_subgroups_core.sv
// ----------------------------------------------------------------------------
// keyed_slot_table_with_subgroups_core
// Table of keyed slots split into equal subgroups, with add, remove, move,
// find, subgroup base, empty test, subgroup count, read and leader test.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction (opcode, member_key, slot_index);
//   out_ch returns exactly one result transaction per request, in order.
//   cfg_we/cfg_index/cfg_data write wide_mode (0), leader_key (1) and
//   leader_present (2); write them only while no request is in flight.
// Sequence, from request acceptance to result valid on out_ch:
//   leader test, empty test, out-of-range and unknown opcodes go straight to
//   the result; read takes one registered read of the key memory; add, remove,
//   find, subgroup base and subgroup count scan the key memory one slot per
//   cycle with a registered read; a move then adds the swap (one read, two
//   writes to the single-write-port key memory).
// Throughput: one request at a time; the next request is taken the cycle
//   after the previous result has moved into the output register.
// Reset clears all slot valid bits, the occupancy count and the configuration
//   registers; the key memory itself is not cleared and needs no sweep.
// A stalled receiver holds the result in the output register; the core can
//   finish one more request behind it and then waits.
// ----------------------------------------------------------------------------
module keyed_slot_table_with_subgroups_core
    import ksts_pkg::*;
#(
    parameter int  TABLE_SLOTS    = 32,
    parameter int  SUBGROUP_SLOTS = 8,
    parameter int  KEY_BITS       = 16,
    localparam int SLOT_BITS      = $clog2(TABLE_SLOTS),
    localparam int SUB_CNT_BITS   = $clog2(SUBGROUP_SLOTS + 1),
    localparam int MEM_CNT_BITS   = $clog2(TABLE_SLOTS + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    ksts_in_if.sink                 in_ch,
    ksts_out_if.source              out_ch,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [KEY_BITS-1:0]     cfg_data
);

    logic                    res_valid;
    logic                    res_take;
    logic                    res_ok;
    logic [SLOT_BITS-1:0]    res_slot;
    logic [KEY_BITS-1:0]     res_key;
    logic                    res_key_valid;
    logic [SUB_CNT_BITS-1:0] res_sub_count;
    logic [MEM_CNT_BITS-1:0] res_mem_count;

    logic                    ram_we;
    logic [SLOT_BITS-1:0]    ram_waddr;
    logic [KEY_BITS-1:0]     ram_wdata;
    logic [SLOT_BITS-1:0]    ram_raddr;
    logic [KEY_BITS-1:0]     ram_rdata;

    logic                    out_valid_reg,    out_valid_next;
    logic                    out_ok_reg;
    logic [SLOT_BITS-1:0]    out_slot_reg;
    logic [KEY_BITS-1:0]     out_key_reg;
    logic                    out_key_valid_reg;
    logic [SUB_CNT_BITS-1:0] out_sub_count_reg;
    logic [MEM_CNT_BITS-1:0] out_mem_count_reg;

    // Sequencer with valid bits, occupancy and configuration registers.
    ksts_engine #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .SUBGROUP_SLOTS (SUBGROUP_SLOTS),
        .KEY_BITS       (KEY_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (in_ch.valid),
        .req_ready     (in_ch.ready),
        .req_opcode    (in_ch.opcode),
        .req_key       (in_ch.member_key),
        .req_slot      (in_ch.slot_index),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res_ok        (res_ok),
        .res_slot      (res_slot),
        .res_key       (res_key),
        .res_key_valid (res_key_valid),
        .res_sub_count (res_sub_count),
        .res_mem_count (res_mem_count),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    // Key memory, one entry per slot.
    ksts_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: takes a finished result when empty or being drained.
    assign res_take       = res_valid && (!out_valid_reg || out_ch.ready);
    assign out_valid_next = res_take || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, loaded with each transaction moved out of the core.
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_ok_reg        <= res_ok;
            out_slot_reg      <= res_slot;
            out_key_reg       <= res_key;
            out_key_valid_reg <= res_key_valid;
            out_sub_count_reg <= res_sub_count;
            out_mem_count_reg <= res_mem_count;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.ok             = out_ok_reg;
    assign out_ch.slot_out       = out_slot_reg;
    assign out_ch.key_out        = out_key_reg;
    assign out_ch.key_valid      = out_key_valid_reg;
    assign out_ch.subgroup_count = out_sub_count_reg;
    assign out_ch.member_count   = out_mem_count_reg;

endmodule

// File: dv/tb_keyed_slot_table_with_subgroups_core.sv
// ----------------------------------------------------------------------------
// tb_keyed_slot_table_with_subgroups_core
// Self-checking bench for the keyed slot table. A short table of directed
// requests covers the field extremes, every opcode and the corner cases. Random
// requests then run under several register settings. Each result transaction
// is compared with an in-order queue filled by a behavioral model of the
// table or, for typed directed rows, by hand. Both channels idle and stall
// at random, with one long result back-pressure and one full drain per phase.
// ----------------------------------------------------------------------------
module tb_keyed_slot_table_with_subgroups_core;
    import ksts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS    = 32;
    localparam int SUBGROUP_SLOTS = 8;
    localparam int KEY_BITS       = 16;
    localparam int SLOT_BITS      = 5;
    localparam int SUB_CNT_BITS   = 4;
    localparam int MEM_CNT_BITS   = 6;

    localparam int NO_SLOT        = -1;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 175;
    localparam int HOLD_AT        = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int PAUSE_AT       = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 50;
    localparam int LIMIT_CYCLES   = 500000;
    localparam int DIRECTED_COUNT = 27;

    // Opcodes that the block does not decode.
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OPCODE_BITS-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [KEY_BITS-1:0]    key;
        logic [SLOT_BITS-1:0]   slot;
    } table_request_t;

    typedef struct packed {
        logic                    ok;
        logic [SLOT_BITS-1:0]    slot;
        logic [KEY_BITS-1:0]     key;
        logic                    key_valid;
        logic [SUB_CNT_BITS-1:0] sub_count;
        logic [MEM_CNT_BITS-1:0] mem_count;
    } table_result_t;

    typedef struct {
        table_request_t req;
        bit             typed;
        table_result_t  want;
    } directed_row_t;

    localparam table_result_t NO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [KEY_BITS-1:0]     cfg_data;

    ksts_in_if  #(.KEY_BITS(KEY_BITS), .SLOT_BITS(SLOT_BITS)) req_ch ();
    ksts_out_if #(
        .KEY_BITS(KEY_BITS), .SLOT_BITS(SLOT_BITS),
        .SUB_CNT_BITS(SUB_CNT_BITS), .MEM_CNT_BITS(MEM_CNT_BITS)
    ) rsp_ch ();

    keyed_slot_table_with_subgroups_core #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .SUBGROUP_SLOTS(SUBGROUP_SLOTS),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(req_ch),
        .out_ch(rsp_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Model state: the table, its occupancy and the configuration registers.
    logic [KEY_BITS-1:0] slot_key [TABLE_SLOTS];
    bit                  slot_used [TABLE_SLOTS];
    bit                  slot_written [TABLE_SLOTS];
    int                  occupied_count;
    bit                  cfg_wide;
    logic [KEY_BITS-1:0] cfg_leader;
    bit                  cfg_leader_on;

    table_result_t pending_results [$];
    int            mismatches;
    int            cycle_count;
    bit            sink_hold_request;

    // Directed requests; rows marked typed carry an expectation written by hand.
    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        '{'{OP_LEADER, 16'h0000, 5'd0},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_EMPTY,  16'h0000, 5'd0},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_EMPTY,  16'hFFFF, 5'd31}, 1'b1, '{1'b1, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_COUNT,  16'h0000, 5'd31}, 1'b1, '{1'b1, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_FIND,   16'hFFFF, 5'd0},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_REMOVE, 16'h0000, 5'd0},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_BASE,   16'h1234, 5'd0},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_MOVE,   16'h0000, 5'd3},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd0}},
        '{'{OP_ADD,    16'h0000, 5'd0},  1'b1, '{1'b1, 5'd0, 16'h0, 1'b0, 4'd0, 6'd1}},
        '{'{OP_ADD,    16'hFFFF, 5'd31}, 1'b1, '{1'b1, 5'd1, 16'h0, 1'b0, 4'd0, 6'd2}},
        '{'{OP_ADD,    16'hFFFF, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_ADD,    16'h8000, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_ADD,    16'h0001, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_ADD,    16'h00FF, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_ADD,    16'hA5A5, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_ADD,    16'h5A5A, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_ADD,    16'h1234, 5'd0},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd8}},
        '{'{OP_READ,   16'h0000, 5'd1},  1'b0, NO_RESULT},
        '{'{OP_MOVE,   16'hFFFF, 5'd1},  1'b1, '{1'b0, 5'd0, 16'h0, 1'b0, 4'd0, 6'd8}},
        '{'{OP_MOVE,   16'h0000, 5'd6},  1'b0, NO_RESULT},
        '{'{OP_READ,   16'h0000, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_BASE,   16'h5A5A, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_COUNT,  16'h0000, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_REMOVE, 16'hFFFF, 5'd0},  1'b0, NO_RESULT},
        '{'{OP_EMPTY,  16'h0000, 5'd1},  1'b0, NO_RESULT},
        '{'{OP_UNUSED_HI, 16'hFFFF, 5'd31}, 1'b0, NO_RESULT},
        '{'{OP_UNUSED_LO, 16'h0000, 5'd0},  1'b0, NO_RESULT}
    };

    // Free-running clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Lowest occupied slot that holds the key, or NO_SLOT.
    function automatic int locate_key(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (slot_used[i] && slot_key[i] == key)
                return i;
        end
        return NO_SLOT;
    endfunction

    // Lowest free slot within the range that the add mode allows.
    function automatic int first_free_slot();
        int lim;
        lim = cfg_wide ? TABLE_SLOTS : SUBGROUP_SLOTS;
        for (int i = 0; i < lim; i++)
        begin
            if (!slot_used[i])
                return i;
        end
        return NO_SLOT;
    endfunction

    // Applies one request to the model table and returns the result it gives.
    function automatic table_result_t apply_request(table_request_t req);
        table_result_t       res;
        int                  hit;
        int                  base;
        int                  target;
        logic [KEY_BITS-1:0] held_key;
        bit                  held_used;
        bit                  held_written;
        res = '0;
        target = int'(req.slot);
        case (req.opcode)
            OP_ADD:
            begin
                hit = first_free_slot();
                if (hit != NO_SLOT)
                begin
                    slot_key[hit]     = req.key;
                    slot_used[hit]    = 1'b1;
                    slot_written[hit] = 1'b1;
                    occupied_count++;
                    res.ok   = 1'b1;
                    res.slot = hit[SLOT_BITS-1:0];
                end
            end
            OP_REMOVE:
            begin
                hit = locate_key(req.key);
                if (hit != NO_SLOT)
                begin
                    slot_used[hit] = 1'b0;
                    slot_key[hit]  = '0;
                    occupied_count--;
                    res.ok = 1'b1;
                end
            end
            OP_MOVE:
            begin
                hit = locate_key(req.key);
                if (hit != NO_SLOT && hit != target && target < TABLE_SLOTS)
                begin
                    // The target's former content, empty or not, goes to the old slot.
                    held_key     = slot_key[target];
                    held_used    = slot_used[target];
                    held_written = slot_written[target];
                    slot_key[hit]        = held_key;
                    slot_used[hit]       = held_used;
                    slot_written[hit]    = held_written;
                    slot_key[target]     = req.key;
                    slot_used[target]    = 1'b1;
                    slot_written[target] = 1'b1;
                    res.ok = 1'b1;
                end
            end
            OP_FIND:
            begin
                hit = locate_key(req.key);
                if (hit != NO_SLOT)
                begin
                    res.ok   = 1'b1;
                    res.slot = hit[SLOT_BITS-1:0];
                end
            end
            OP_BASE:
            begin
                hit = locate_key(req.key);
                if (hit != NO_SLOT)
                begin
                    base     = (hit / SUBGROUP_SLOTS) * SUBGROUP_SLOTS;
                    res.ok   = 1'b1;
                    res.slot = base[SLOT_BITS-1:0];
                end
            end
            OP_EMPTY:
            begin
                // Slot 0 always reads as not empty.
                if (target > 0 && target < TABLE_SLOTS && !slot_used[target])
                    res.ok = 1'b1;
            end
            OP_COUNT:
            begin
                if (target < TABLE_SLOTS)
                begin
                    base   = (target / SUBGROUP_SLOTS) * SUBGROUP_SLOTS;
                    res.ok = 1'b1;
                    for (int i = base; i < base + SUBGROUP_SLOTS && i < TABLE_SLOTS; i++)
                    begin
                        if (slot_used[i])
                            res.sub_count++;
                    end
                end
            end
            OP_READ:
            begin
                if (target < TABLE_SLOTS && slot_used[target])
                begin
                    res.ok        = 1'b1;
                    res.key_valid = 1'b1;
                    res.key       = slot_key[target];
                end
            end
            OP_LEADER:
            begin
                if (cfg_leader_on && req.key == cfg_leader)
                    res.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.mem_count = occupied_count[MEM_CNT_BITS-1:0];
        return res;
    endfunction

    // Nearest slot at or above the wanted one, wrapping around, whose key has been written.
    function automatic logic [SLOT_BITS-1:0] written_slot_near(logic [SLOT_BITS-1:0] want);
        int s;
        for (int n = 0; n < TABLE_SLOTS; n++)
        begin
            s = (int'(want) + n) % TABLE_SLOTS;
            if (slot_written[s])
                return s[SLOT_BITS-1:0];
        end
        return want;
    endfunction

    // Key drawn from the occupied slots, a pool of edge values, or at random.
    function automatic logic [KEY_BITS-1:0] random_key();
        int start;
        int s;
        case ($urandom_range(0, 3))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'h0000;
                    1: return 16'hFFFF;
                    2: return cfg_leader;
                    3: return 16'h8000;
                    4: return 16'h0001;
                    default: return 16'h7FFF;
                endcase
            end
            1, 2:
            begin
                start = $urandom_range(0, TABLE_SLOTS - 1);
                for (int n = 0; n < TABLE_SLOTS; n++)
                begin
                    s = (start + n) % TABLE_SLOTS;
                    if (slot_used[s])
                        return slot_key[s];
                end
                return 16'($urandom);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Next random request, weighted toward adds and removes of live keys.
    function automatic table_request_t pick_request();
        table_request_t req;
        int             r;
        int             at;
        r = $urandom_range(0, 99);
        req.key  = random_key();
        req.slot = 5'($urandom);
        if (r < 3)
            req.opcode = 4'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
        else if (r < 25)
            req.opcode = OP_ADD;
        else if (r < 41)
            req.opcode = OP_REMOVE;
        else if (r < 53)
            req.opcode = OP_MOVE;
        else if (r < 64)
            req.opcode = OP_FIND;
        else if (r < 72)
            req.opcode = OP_BASE;
        else if (r < 80)
            req.opcode = OP_EMPTY;
        else if (r < 87)
            req.opcode = OP_COUNT;
        else if (r < 95)
            req.opcode = OP_READ;
        else
            req.opcode = OP_LEADER;

        if (req.opcode == OP_LEADER && $urandom_range(0, 1) == 0)
            req.key = cfg_leader;
        // Reads and moves only touch slots whose key has been written once.
        if (req.opcode == OP_READ)
            req.slot = written_slot_near(req.slot);
        if (req.opcode == OP_MOVE)
        begin
            at = locate_key(req.key);
            if (at != NO_SLOT && $urandom_range(0, 4) == 0)
                req.slot = at[SLOT_BITS-1:0];
            else
                req.slot = written_slot_near(req.slot);
        end
        return req;
    endfunction

    // Drives one request, waits for its transaction and queues its expectation.
    task automatic push_request(table_request_t req, bit typed, table_result_t want);
        table_result_t model_res;
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= req.opcode;
        req_ch.member_key <= req.key;
        req_ch.slot_index <= req.slot;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        model_res = apply_request(req);
        pending_results.push_back(typed ? want : model_res);
    endtask

    // Waits until every queued result has arrived, then lets the core settle.
    task automatic wait_for_results();
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers back to back and mirrors them in the model.
    task automatic apply_settings(bit wide, logic [KEY_BITS-1:0] leader, bit present);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDE_MODE;
        cfg_data  <= KEY_BITS'(wide);
        @(posedge clk);
        cfg_index <= CFG_LEADER_KEY;
        cfg_data  <= leader;
        @(posedge clk);
        cfg_index <= CFG_LEADER_PRESENT;
        cfg_data  <= KEY_BITS'(present);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_wide      = wide;
        cfg_leader    = leader;
        cfg_leader_on = present;
        @(posedge clk);
    endtask

    // Reports one field that differs from its expectation.
    function automatic void check_field(string name, logic [KEY_BITS-1:0] want,
                                        logic [KEY_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Result checker: every transaction on the result channel pops one expectation.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("ok", KEY_BITS'(want.ok), KEY_BITS'(rsp_ch.ok));
                check_field("slot_out", KEY_BITS'(want.slot), KEY_BITS'(rsp_ch.slot_out));
                check_field("key_out", want.key, rsp_ch.key_out);
                check_field("key_valid", KEY_BITS'(want.key_valid),
                            KEY_BITS'(rsp_ch.key_valid));
                check_field("subgroup_count", KEY_BITS'(want.sub_count),
                            KEY_BITS'(rsp_ch.subgroup_count));
                check_field("member_count", KEY_BITS'(want.mem_count),
                            KEY_BITS'(rsp_ch.member_count));
            end
        end
    end

    // Result receiver: random duty stretches, plus a long hold when requested.
    initial
    begin : result_sink
        int hold_left;
        int mode_left;
        int duty;
        hold_left = 0;
        mode_left = 0;
        duty = 100;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_request)
            begin
                sink_hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 3))
                        0: duty = 100;
                        1: duty = 75;
                        2: duty = 40;
                        default: duty = 10;
                    endcase
                end
                mode_left--;
                rsp_ch.ready <= ($urandom_range(1, 100) <= duty);
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin : request_source
        table_request_t req;
        int             burst_left;
        int             gap;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_ADD;
        req_ch.member_key <= '0;
        req_ch.slot_index <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_WIDE_MODE;
        cfg_data          <= '0;
        rst_n             <= 1'b0;
        sink_hold_request = 1'b0;
        mismatches        = 0;
        occupied_count    = 0;
        cfg_wide          = 1'b0;
        cfg_leader        = '0;
        cfg_leader_on     = 1'b0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_key[i]     = '0;
            slot_used[i]    = 1'b0;
            slot_written[i] = 1'b0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        apply_settings(1'b0, 16'h0000, 1'b0);

        // Directed table, back to back.
        foreach (directed_rows[i])
            push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        req_ch.valid <= 1'b0;
        wait_for_results();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: apply_settings(1'b1, 16'hFFFF, 1'b1);
                1: apply_settings(1'b1, 16'h0000, 1'b1);
                2: apply_settings(1'b0, 16'($urandom), 1'b1);
                3: apply_settings(1'b1, 16'($urandom), 1'b0);
                4: apply_settings(1'b0, 16'hFFFF, 1'b0);
                default: apply_settings(1'b1, 16'($urandom), 1'b1);
            endcase
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == HOLD_AT)
                    sink_hold_request = 1'b1;
                // Once per phase the source stops until the table has answered everything.
                if (n == PAUSE_AT)
                begin
                    req_ch.valid <= 1'b0;
                    wait_for_results();
                end
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 32);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                    if (gap > 0)
                    begin
                        req_ch.valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;
                req = pick_request();
                push_request(req, 1'b0, NO_RESULT);
            end
            req_ch.valid <= 1'b0;
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
